// File: src/excrt_congruence_merge_assert.svh
// assertion macros for the congruence merge checker
// expects clk and rst_n in the scope of use
`ifndef EXCRT_CONGRUENCE_MERGE_ASSERT_SVH
`define EXCRT_CONGRUENCE_MERGE_ASSERT_SVH

// same-cycle implication
`define EXCM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("excm check failed");

// next-cycle implication
`define EXCM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("excm check failed");

`endif

// File: src/excm_pkg.sv
// shared widths, types and codes for the congruence merge block
// no dependencies
package excm_pkg;

    localparam int VALUE_WIDTH = 63;
    localparam int CW          = VALUE_WIDTH + 2;
    localparam int CNTW        = $clog2(VALUE_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [CW-1:0]   coef_t;
    typedef logic [1:0]             status_t;
    typedef logic [CNTW-1:0]        cnt_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_NOSOL = 2'd1;
    localparam status_t ST_OVF   = 2'd2;

    typedef enum logic {MUL_PLAIN, MUL_MOD} mul_mode_t;

    typedef struct packed {
        logic      start;
        mul_mode_t mode;
    } mul_ctl_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } mul_sts_t;

    localparam cnt_t CNT_LAST = cnt_t'(VALUE_WIDTH - 1);

endpackage

// File: src/excm_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// also accumulates quotient times a signed coefficient; uses excm_pkg
module excm_div
    import excm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  value_t dividend,
    input  value_t divisor,
    input  coef_t  coef,
    output logic   done,
    output value_t quotient,
    output value_t remainder,
    output coef_t  prod
);

    logic   busy_reg, busy_next;
    logic   done_reg, done_next;
    cnt_t   cnt_reg, cnt_next;
    value_t num_reg, rem_reg, den_reg;
    coef_t  coef_reg, prod_reg;

    logic [VALUE_WIDTH:0] trial;
    logic [VALUE_WIDTH:0] diff;
    logic                 ge;

    assign trial = {rem_reg, num_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + cnt_t'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
            coef_reg <= coef;
            prod_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
            num_reg  <= {num_reg[VALUE_WIDTH-2:0], ge};
            prod_reg <= (prod_reg <<< 1) + (ge ? coef_reg : coef_t'(0));
        end
    end

    assign done      = done_reg;
    assign quotient  = num_reg;
    assign remainder = rem_reg;
    assign prod      = prod_reg;

endmodule

// File: src/excm_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
// plain mode flags overflow, modular mode reduces each step; uses excm_pkg
module excm_mul
    import excm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_ctl_t ctl,
    input  value_t   a,
    input  value_t   b,
    input  value_t   m,
    output mul_sts_t sts,
    output value_t   product
);

    logic      busy_reg, busy_next;
    logic      done_reg, done_next;
    cnt_t      cnt_reg, cnt_next;
    mul_mode_t mode_reg;
    value_t    a_reg, b_reg, m_reg, acc_reg;
    logic      ovf_reg;

    logic [VALUE_WIDTH:0]   dbl, dbl_sub, sum_m, sum_sub;
    value_t                 addend, dbl_red;
    logic [VALUE_WIDTH+1:0] plain_sum;

    assign addend    = a_reg[VALUE_WIDTH-1] ? b_reg : value_t'(0);
    assign dbl       = {acc_reg, 1'b0};
    assign dbl_sub   = dbl - {1'b0, m_reg};
    assign dbl_red   = (dbl >= {1'b0, m_reg}) ? dbl_sub[VALUE_WIDTH-1:0]
                                              : dbl[VALUE_WIDTH-1:0];
    assign sum_m     = {1'b0, dbl_red} + {1'b0, addend};
    assign sum_sub   = sum_m - {1'b0, m_reg};
    assign plain_sum = {1'b0, acc_reg, 1'b0} + {2'b00, addend};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + cnt_t'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            mode_reg <= ctl.mode;
            a_reg    <= a;
            b_reg    <= b;
            m_reg    <= m;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            a_reg <= {a_reg[VALUE_WIDTH-2:0], 1'b0};
            if (mode_reg == MUL_MOD)
            begin
                acc_reg <= (sum_m >= {1'b0, m_reg}) ? sum_sub[VALUE_WIDTH-1:0]
                                                    : sum_m[VALUE_WIDTH-1:0];
            end
            else
            begin
                acc_reg <= plain_sum[VALUE_WIDTH-1:0];
                ovf_reg <= ovf_reg | (|plain_sum[VALUE_WIDTH+1:VALUE_WIDTH]);
            end
        end
    end

    assign sts.done = done_reg;
    assign sts.ovf  = ovf_reg;
    assign product  = acc_reg;

endmodule

// File: src/excrt_congruence_merge.sv
// congruence merge top level: sequencer, accumulator and output register
// instantiates excm_div and excm_mul; uses excm_pkg
//
// usage
//   input channel: in_valid / in_stall carry modulus, residue, restart
//   output channel: out_valid / out_stall carry combined_residue,
//   combined_modulus and status (0 ok, 1 no solution, 2 overflow)
//   one result per input transfer, in order
// sequencing
//   one item at a time; in_stall is high from a transfer until its result
//   is loaded into the output register, and the next transfer may come in
//   the cycle after the load; a fully merged item runs the extended euclid
//   steps, each a check state and one divider pass, and nine more divider
//   and multiplier passes before it is loaded; an item held by a sticky
//   status skips them and is loaded as soon as the output register is free
// reset
//   accumulator goes to modulus 1, residue 0, status ok; no output valid
// stall
//   the result waits in the output register while out_stall is high; the
//   next item may be taken and then waits, in_stall high, until it is free
module excrt_congruence_merge
    import excm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  value_t  modulus,
    input  value_t  residue,
    input  logic    restart,
    output logic    out_valid,
    input  logic    out_stall,
    output value_t  combined_residue,
    output value_t  combined_modulus,
    output status_t status
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RRED = 4'd1;
    localparam logic [3:0] S_R1M  = 4'd2;
    localparam logic [3:0] S_ECHK = 4'd3;
    localparam logic [3:0] S_EDIV = 4'd4;
    localparam logic [3:0] S_KDIV = 4'd5;
    localparam logic [3:0] S_M1G  = 4'd6;
    localparam logic [3:0] S_M2G  = 4'd7;
    localparam logic [3:0] S_LCM  = 4'd8;
    localparam logic [3:0] S_INV  = 4'd9;
    localparam logic [3:0] S_XMUL = 4'd10;
    localparam logic [3:0] S_RMUL = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       go_reg, go_next;
    logic       out_valid_reg, out_valid_next;
    value_t     acc_mod_reg, acc_mod_next;
    value_t     acc_res_reg, acc_res_next;
    status_t    sticky_reg, sticky_next;

    value_t  m2_reg, r2_reg, d_reg, er0_reg, er1_reg, k_reg;
    value_t  m1g_reg, m2g_reg, lcm_reg, inv_reg;
    coef_t   s0_reg, s1_reg;
    value_t  out_res_reg, out_mod_reg;
    status_t out_sts_reg;

    logic     div_done;
    value_t   div_dividend, div_divisor, div_q, div_r;
    coef_t    div_coef, div_prod;
    mul_ctl_t mul_ctl;
    mul_sts_t mul_sts;
    value_t   mul_a, mul_b, mul_product;

    logic                 accept, load_out;
    status_t              sticky_eff;
    logic [VALUE_WIDTH:0] d_full, res_sum;
    coef_t                s0_abs;
    value_t               inv_neg;

    assign accept     = in_valid && (state_reg == S_IDLE);
    assign in_stall   = state_reg != S_IDLE;
    assign load_out   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign sticky_eff = restart ? ST_OK : sticky_reg;

    assign d_full  = (r2_reg >= div_r) ? {1'b0, r2_reg} - {1'b0, div_r}
                                       : {1'b0, r2_reg} + {1'b0, m2_reg} - {1'b0, div_r};
    assign res_sum = {1'b0, acc_res_reg} + {1'b0, mul_product};
    assign s0_abs  = s0_reg[CW-1] ? -s0_reg : s0_reg;
    assign inv_neg = m2g_reg - div_r;

    always_comb
    begin
        div_dividend = r2_reg;
        div_divisor  = m2_reg;
        div_coef     = '0;
        case (state_reg)
            S_R1M:
            begin
                div_dividend = acc_res_reg;
            end
            S_EDIV:
            begin
                div_dividend = er0_reg;
                div_divisor  = er1_reg;
                div_coef     = s1_reg;
            end
            S_KDIV:
            begin
                div_dividend = d_reg;
                div_divisor  = er0_reg;
            end
            S_M1G:
            begin
                div_dividend = acc_mod_reg;
                div_divisor  = er0_reg;
            end
            S_M2G:
            begin
                div_dividend = m2_reg;
                div_divisor  = er0_reg;
            end
            S_INV:
            begin
                div_dividend = s0_abs[VALUE_WIDTH-1:0];
                div_divisor  = m2g_reg;
            end
            default:
            begin
                div_dividend = r2_reg;
            end
        endcase
    end

    always_comb
    begin
        mul_ctl.start = go_reg && (state_reg inside {S_LCM, S_XMUL, S_RMUL});
        mul_ctl.mode  = MUL_PLAIN;
        mul_a         = m2_reg;
        mul_b         = m1g_reg;
        case (state_reg)
            S_XMUL:
            begin
                mul_ctl.mode = MUL_MOD;
                mul_a        = k_reg;
                mul_b        = inv_reg;
            end
            S_RMUL:
            begin
                mul_a = k_reg;
                mul_b = acc_mod_reg;
            end
            default:
            begin
                mul_a = m2_reg;
            end
        endcase
    end

    excm_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (go_reg && !(state_reg inside {S_LCM, S_XMUL, S_RMUL})),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .coef      (div_coef),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r),
        .prod      (div_prod)
    );

    excm_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mul_ctl),
        .a       (mul_a),
        .b       (mul_b),
        .m       (m2g_reg),
        .sts     (mul_sts),
        .product (mul_product)
    );

    always_comb
    begin
        state_next     = state_reg;
        go_next        = 1'b0;
        acc_mod_next   = acc_mod_reg;
        acc_res_next   = acc_res_reg;
        sticky_next    = sticky_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (restart)
                    begin
                        acc_mod_next = value_t'(1);
                        acc_res_next = '0;
                        sticky_next  = ST_OK;
                    end
                    if (sticky_eff != ST_OK)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RRED;
                        go_next    = 1'b1;
                    end
                end
            end
            S_RRED:
            begin
                if (div_done)
                begin
                    state_next = S_R1M;
                    go_next    = 1'b1;
                end
            end
            S_R1M:
            begin
                if (div_done)
                begin
                    state_next = S_ECHK;
                end
            end
            S_ECHK:
            begin
                go_next    = 1'b1;
                state_next = (er1_reg == '0) ? S_KDIV : S_EDIV;
            end
            S_EDIV:
            begin
                if (div_done)
                begin
                    state_next = S_ECHK;
                end
            end
            S_KDIV:
            begin
                if (div_done)
                begin
                    if (div_r != '0)
                    begin
                        sticky_next = ST_NOSOL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_M1G;
                        go_next    = 1'b1;
                    end
                end
            end
            S_M1G:
            begin
                if (div_done)
                begin
                    state_next = S_M2G;
                    go_next    = 1'b1;
                end
            end
            S_M2G:
            begin
                if (div_done)
                begin
                    state_next = S_LCM;
                    go_next    = 1'b1;
                end
            end
            S_LCM:
            begin
                if (mul_sts.done)
                begin
                    if (mul_sts.ovf)
                    begin
                        sticky_next = ST_OVF;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_INV;
                        go_next    = 1'b1;
                    end
                end
            end
            S_INV:
            begin
                if (div_done)
                begin
                    state_next = S_XMUL;
                    go_next    = 1'b1;
                end
            end
            S_XMUL:
            begin
                if (mul_sts.done)
                begin
                    state_next = S_RMUL;
                    go_next    = 1'b1;
                end
            end
            S_RMUL:
            begin
                if (mul_sts.done)
                begin
                    acc_res_next = res_sum[VALUE_WIDTH-1:0];
                    acc_mod_next = lcm_reg;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_mod_reg   <= value_t'(1);
            acc_res_reg   <= '0;
            sticky_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            out_valid_reg <= out_valid_next;
            acc_mod_reg   <= acc_mod_next;
            acc_res_reg   <= acc_res_next;
            sticky_reg    <= sticky_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m2_reg <= (modulus == '0) ? value_t'(1) : modulus;
            r2_reg <= residue;
        end
        if (div_done)
        begin
            case (state_reg)
                S_RRED:
                begin
                    r2_reg <= div_r;
                end
                S_R1M:
                begin
                    d_reg   <= d_full[VALUE_WIDTH-1:0];
                    er0_reg <= acc_mod_reg;
                    er1_reg <= m2_reg;
                    s0_reg  <= coef_t'(1);
                    s1_reg  <= '0;
                end
                S_EDIV:
                begin
                    er0_reg <= er1_reg;
                    er1_reg <= div_r;
                    s0_reg  <= s1_reg;
                    s1_reg  <= s0_reg - div_prod;
                end
                S_KDIV:
                begin
                    k_reg <= div_q;
                end
                S_M1G:
                begin
                    m1g_reg <= div_q;
                end
                S_M2G:
                begin
                    m2g_reg <= div_q;
                end
                S_INV:
                begin
                    inv_reg <= (s0_reg[CW-1] && div_r != '0) ? inv_neg : div_r;
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
        if (mul_sts.done)
        begin
            case (state_reg)
                S_LCM:
                begin
                    lcm_reg <= mul_product;
                end
                S_XMUL:
                begin
                    k_reg <= mul_product;
                end
                default:
                begin
                    lcm_reg <= lcm_reg;
                end
            endcase
        end
        if (load_out)
        begin
            out_res_reg <= acc_res_reg;
            out_mod_reg <= acc_mod_reg;
            out_sts_reg <= sticky_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign combined_residue = out_res_reg;
    assign combined_modulus = out_mod_reg;
    assign status           = out_sts_reg;

endmodule

// File: src/excm_checker.sv
// port-level checker for the congruence merge block, bound to the top level
// uses excm_pkg and excrt_congruence_merge_assert.svh
`include "excrt_congruence_merge_assert.svh"

module excm_checker
    import excm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_stall,
    input logic    out_valid,
    input logic    out_stall,
    input value_t  combined_residue,
    input value_t  combined_modulus,
    input status_t status
);

    `EXCM_ASSERT_NOW(a_status_code, out_valid, status <= ST_OVF)
    `EXCM_ASSERT_NOW(a_residue_below, out_valid, combined_residue < combined_modulus)
    `EXCM_ASSERT_NXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)
    `EXCM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(combined_modulus))

endmodule

bind excrt_congruence_merge excm_checker u_excm_checker (.*);
